FILE: design/dwd_pkg.sv
package dwd_pkg;

	localparam logic [7:0]  CHAR_TAB  = 8'h09;
	localparam logic [7:0]  CHAR_NL   = 8'h0a;
	localparam logic [7:0]  CHAR_CR   = 8'h0d;
	localparam logic [7:0]  CHAR_SP   = 8'h20;
	localparam logic [7:0]  CHAR_UA   = 8'h41;
	localparam logic [7:0]  CHAR_UZ   = 8'h5a;
	localparam logic [7:0]  CHAR_LA   = 8'h61;
	localparam logic [7:0]  CHAR_LZ   = 8'h7a;
	localparam logic [7:0]  CASE_BIT  = 8'h20;
	localparam logic [31:0] LINE_MAX  = 32'hffff_ffff;
	localparam logic [15:0] TOTAL_MAX = 16'hffff;

	// what the front end tells the close stage about one byte
	typedef struct packed {
		logic res;       // byte closes a word
		logic rst;       // end of text, restart stream after this byte
		logic wr;        // word byte stored and compared
		logic len_over;  // no byte of the previous word at this position
		logic swl;       // open word starts with a letter
	} dwd_ctl_t;

	typedef struct packed {
		logic        dup_report;
		logic [15:0] dup_total;
		logic [31:0] word_line;
		logic [6:0]  word_length;
	} dwd_res_t;

endpackage

FILE: design/doubled_word_detector_core.sv
// Result path: the byte that closes a word (separator or end of text) passes the
// front-end stage register, then the output register (via the skid while stalled).
// Throughput: one byte per cycle, set by the word store's one write and one
// read port, each used at most once per byte; full rate while results are taken.
// Reset (arst_n, async): control and counters cleared, line 1, report_mode 1;
// word store contents are not cleared.
module doubled_word_detector_core #(
	parameter int WORD_BUFFER = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	output logic        rep_valid,
	input  logic        rep_stall,
	output logic        dup_report,
	output logic [15:0] dup_total,
	output logic [31:0] word_line,
	output logic [6:0]  word_length
);
	import dwd_pkg::*;

	localparam int LEN_W = $clog2(WORD_BUFFER);

	logic             s1_go;
	logic             fire;
	logic             sk_full;
	logic             push;
	dwd_res_t         res;

	logic             mem_we;
	logic [LEN_W:0]   mem_waddr;
	logic [7:0]       mem_wdata;
	logic [LEN_W:0]   mem_raddr;
	logic [7:0]       mem_rdata;

	logic             s1_valid;
	dwd_ctl_t         s1_ctl;
	logic [7:0]       s1_char;
	logic [LEN_W-1:0] s1_cur_len;
	logic [LEN_W-1:0] s1_prev_len;
	logic [31:0]      s1_line;

	// only a closing byte needs room in the output stage
	assign s1_go      = ~(s1_valid & s1_ctl.res & sk_full);
	assign text_stall = ~s1_go;
	assign fire       = s1_valid & s1_go;

	dwd_front #(
		.WORD_BUFFER (WORD_BUFFER),
		.LEN_W       (LEN_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.s1_go       (s1_go),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.s1_valid    (s1_valid),
		.s1_ctl      (s1_ctl),
		.s1_char     (s1_char),
		.s1_cur_len  (s1_cur_len),
		.s1_prev_len (s1_prev_len),
		.s1_line     (s1_line)
	);

	dwd_word_store #(
		.ADDR_W (LEN_W + 1)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_we),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	dwd_close #(
		.LEN_W (LEN_W)
	) u_close (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.ctl       (s1_ctl),
		.char_in   (s1_char),
		.rdata     (mem_rdata),
		.cur_len   (s1_cur_len),
		.prev_len  (s1_prev_len),
		.line      (s1_line),
		.push      (push),
		.res       (res)
	);

	dwd_out_skid u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.res         (res),
		.rep_stall   (rep_stall),
		.rep_valid   (rep_valid),
		.full        (sk_full),
		.dup_report  (dup_report),
		.dup_total   (dup_total),
		.word_line   (word_line),
		.word_length (word_length)
	);

endmodule

FILE: design/dwd_word_store.sv
module dwd_word_store #(
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [2**ADDR_W];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// held while the close stage waits
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/dwd_front.sv
module dwd_front #(
	parameter int WORD_BUFFER = 128,
	parameter int LEN_W       = $clog2(WORD_BUFFER)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	input  logic [7:0]           char_code,
	input  logic                 end_of_text,
	input  logic                 s1_go,
	output logic                 mem_we,
	output logic [LEN_W:0]       mem_waddr,
	output logic [7:0]           mem_wdata,
	output logic [LEN_W:0]       mem_raddr,
	output logic                 s1_valid,
	output dwd_pkg::dwd_ctl_t    s1_ctl,
	output logic [7:0]           s1_char,
	output logic [LEN_W-1:0]     s1_cur_len,
	output logic [LEN_W-1:0]     s1_prev_len,
	output logic [31:0]          s1_line
);
	import dwd_pkg::*;

	logic             accept;
	logic [7:0]       lc;
	logic             is_sp;
	logic             is_letter;
	logic             room;
	logic             take_char;

	logic             bank_q;
	logic [LEN_W-1:0] cur_len_q;
	logic [LEN_W-1:0] prev_len_q;
	logic             inside_q;
	logic             swl_q;
	logic [31:0]      line_q;

	logic             valid_s1;
	dwd_ctl_t         ctl_s1;
	logic [7:0]       char_s1;
	logic [LEN_W-1:0] cur_len_s1;
	logic [LEN_W-1:0] prev_len_s1;
	logic [31:0]      line_s1;

	assign accept = text_valid & s1_go;

	always_comb begin
		lc = char_code;
		if (char_code inside {[CHAR_UA:CHAR_UZ]}) begin
			lc = char_code | CASE_BIT;
		end
		is_letter = lc inside {[CHAR_LA:CHAR_LZ]};
		case (char_code) inside
			CHAR_SP, [CHAR_TAB:CHAR_CR]: is_sp = 1'b1;
			default:                     is_sp = 1'b0;
		endcase
		room      = cur_len_q < LEN_W'(WORD_BUFFER - 1);
		take_char = ~end_of_text & ~is_sp & room;
	end

	// byte goes into the bank being written, the opposite bank holds the previous word
	assign mem_we    = accept & take_char;
	assign mem_waddr = {bank_q, cur_len_q};
	assign mem_wdata = lc;
	assign mem_raddr = {~bank_q, cur_len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q     <= 1'b0;
			cur_len_q  <= '0;
			prev_len_q <= '0;
			inside_q   <= 1'b0;
			swl_q      <= 1'b0;
			line_q     <= 32'd1;
		end else if (accept) begin
			if (end_of_text) begin
				bank_q     <= 1'b0;
				cur_len_q  <= '0;
				prev_len_q <= '0;
				inside_q   <= 1'b0;
				swl_q      <= 1'b0;
				line_q     <= 32'd1;
			end else if (is_sp) begin
				if (inside_q) begin
					prev_len_q <= cur_len_q;
					bank_q     <= ~bank_q;
					cur_len_q  <= '0;
					inside_q   <= 1'b0;
					swl_q      <= 1'b0;
				end
				if (char_code == CHAR_NL && line_q != LINE_MAX) begin
					line_q <= line_q + 32'd1;
				end
			end else begin
				if (!inside_q) begin
					inside_q <= 1'b1;
					swl_q    <= is_letter;
				end
				if (room) begin
					cur_len_q <= cur_len_q + LEN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_go) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.res      <= (end_of_text | is_sp) & inside_q;
			ctl_s1.rst      <= end_of_text;
			ctl_s1.wr       <= take_char;
			ctl_s1.len_over <= cur_len_q >= prev_len_q;
			ctl_s1.swl      <= swl_q;
			char_s1         <= lc;
			cur_len_s1      <= cur_len_q;
			prev_len_s1     <= prev_len_q;
			line_s1         <= line_q;
		end
	end

	assign s1_valid    = valid_s1;
	assign s1_ctl      = ctl_s1;
	assign s1_char     = char_s1;
	assign s1_cur_len  = cur_len_s1;
	assign s1_prev_len = prev_len_s1;
	assign s1_line     = line_s1;

`ifndef ASSERT_OFF
	a_eot_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_text |=> line_q == 32'd1 && !inside_q && cur_len_q == '0)
		else $error("stream state not restarted after end of text");
`endif

endmodule

FILE: design/dwd_close.sv
module dwd_close #(
	parameter int LEN_W = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  logic                 fire,
	input  dwd_pkg::dwd_ctl_t    ctl,
	input  logic [7:0]           char_in,
	input  logic [7:0]           rdata,
	input  logic [LEN_W-1:0]     cur_len,
	input  logic [LEN_W-1:0]     prev_len,
	input  logic [31:0]          line,
	output logic                 push,
	output dwd_pkg::dwd_res_t    res
);
	import dwd_pkg::*;

	logic        mode_q;
	logic        mm_q;
	logic        streak_q;
	logic [15:0] total_q;

	logic        dup;
	logic        report;
	logic [15:0] total_nx;
	logic [15:0] len_ext;

	always_comb begin
		dup      = ctl.swl & ~mm_q & (cur_len == prev_len);
		report   = dup & (~mode_q | ~streak_q);
		total_nx = (report && total_q != TOTAL_MAX) ? total_q + 16'd1 : total_q;
		len_ext  = 16'(cur_len);
		res.dup_report  = report;
		res.dup_total   = total_nx;
		res.word_line   = line;
		res.word_length = len_ext[6:0];
	end

	assign push = fire & ctl.res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_q     <= 1'b0;
			streak_q <= 1'b0;
			total_q  <= '0;
		end else if (fire) begin
			if (ctl.res) begin
				streak_q <= dup;
				total_q  <= total_nx;
				mm_q     <= 1'b0;
			end else if (ctl.wr && (ctl.len_over || rdata != char_in)) begin
				mm_q <= 1'b1;
			end
			if (ctl.rst) begin
				streak_q <= 1'b0;
				total_q  <= '0;
				mm_q     <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_streak_set: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ctl.res && report && !ctl.rst |=> streak_q && !mm_q)
		else $error("streak not opened after a report");
	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && report |-> res.dup_total != 16'd0)
		else $error("report with zero total");
`endif

endmodule

FILE: design/dwd_out_skid.sv
module dwd_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dwd_pkg::dwd_res_t res,
	input  logic              rep_stall,
	output logic              rep_valid,
	output logic              full,
	output logic              dup_report,
	output logic [15:0]       dup_total,
	output logic [31:0]       word_line,
	output logic [6:0]        word_length
);
	import dwd_pkg::*;

	logic     out_valid_q;
	logic     sk_valid_q;
	dwd_res_t out_q;
	dwd_res_t sk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (!out_valid_q || !rep_stall) begin
			out_valid_q <= sk_valid_q | push;
			sk_valid_q  <= 1'b0;
		end else if (push) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !rep_stall) begin
			out_q <= sk_valid_q ? sk_q : res;
		end else if (push) begin
			sk_q <= res;
		end
	end

	assign rep_valid   = out_valid_q;
	assign full        = sk_valid_q;
	assign dup_report  = out_q.dup_report;
	assign dup_total   = out_q.dup_total;
	assign word_line   = out_q.word_line;
	assign word_length = out_q.word_length;

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |-> out_valid_q)
		else $error("skid entry without output entry");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !sk_valid_q)
		else $error("result pushed into full skid");
`endif

endmodule
